/* design/dchrono_pkg.sv */
// dchrono_pkg: shared types, widths, register codes and reset values for the
// debounced chronograph. No dependencies; imported by debounced_chronograph.
package dchrono_pkg;

   localparam int TIME_WIDTH_DEFAULT = 48;
   localparam int STAMP_W            = 48;   // width of the timestamp / interval fields
   localparam int DEBOUNCE_W         = 20;
   localparam int DIST_W             = 20;
   localparam int MASS_W             = 16;
   localparam int CSR_DATA_W         = 20;
   localparam int CSR_IDX_W          = 2;
   localparam int RESULT_W           = 32;

   // Shared shift register for products, dividends and quotients.
   // mass * D^2 < 2^56, so 56 bits cover the widest numerator.
   localparam int ACC_W      = MASS_W + 2 * DIST_W;
   localparam int SQ_W       = 2 * DIST_W;
   localparam int SPEED_BITS = 30;            // D * 1000 < 2^30
   localparam int DIV_ITER   = ACC_W;
   localparam int CNT_W      = $clog2(DIV_ITER);

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASS_A   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASS_B   = 2'd3;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 20'd200;
   localparam logic [DIST_W-1:0]     DIST_RESET     = 20'd68169;
   localparam logic [MASS_W-1:0]     MASS_A_RESET   = 16'd200;
   localparam logic [MASS_W-1:0]     MASS_B_RESET   = 16'd300;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPEED,
      ST_SQ,
      ST_EA_MUL,
      ST_EA_DIV1,
      ST_EA_DIV2,
      ST_EB_MUL,
      ST_EB_DIV1,
      ST_EB_DIV2,
      ST_FINISH
   } state_type;

   // Quotient of mass*D^2 / dt / dt, halved and clipped to 32 bits.
   function automatic logic [RESULT_W-1:0] energy_sat(input logic [ACC_W-1:0] q);
      logic [RESULT_W-1:0] res;
      if (|q[ACC_W-1:RESULT_W+1]) begin
         res = '1;
      end else begin
         res = q[RESULT_W:1];
      end
      return res;
   endfunction

endpackage

/* design/debounced_chronograph.sv */
// debounced_chronograph: light-gate edge debounce, interval, speed and energy.
// Depends on dchrono_pkg (widths, register codes, state type, saturation).
//
// Usage
//   req_*: one transaction per falling gate edge, timestamp in microseconds.
//   rsp_*: one transaction per edge: accepted flag, stored interval, speed
//          (mm/s) and kinetic energy for two masses (uJ), speed_valid low and
//          all results zero while the stored interval is zero.
//   csr_*: write-only registers (debounce, gate distance, mass a, mass b),
//          to be written by the user only while the block is idle; the block
//          does not enforce this. Unknown indexes are ignored.
// Sequencing
//   An edge with a zero interval goes from idle straight to the final state,
//   then into the result register. Otherwise one shared bit-serial unit does
//   the arithmetic one bit per cycle: a 30-step divide for speed, a 20-step
//   shift-add square of the distance, and per mass a 16-step shift-add
//   multiply and two 56-step divides (by dt, then by dt again). A new edge is
//   taken only after the final state has passed its result on.
// Reset
//   Synchronous, active high: registers go to their documented defaults, the
//   edge history and stored interval clear to zero, no result is pending.
// Back-pressure
//   Results sit in an output register; the next edge is taken while one waits.
//   A finished result holds in the final state until that register is free.
module debounced_chronograph #(
   parameter int TIME_WIDTH = dchrono_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [dchrono_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dchrono_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // edge transactions
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dchrono_pkg::STAMP_W-1:0]       req_edge_time_us,
   // result transactions
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_accepted,
   output logic [dchrono_pkg::STAMP_W-1:0]       rsp_interval_us,
   output logic                                  rsp_speed_valid,
   output logic [dchrono_pkg::RESULT_W-1:0]      rsp_speed_mm_s,
   output logic [dchrono_pkg::RESULT_W-1:0]      rsp_energy_a_uj,
   output logic [dchrono_pkg::RESULT_W-1:0]      rsp_energy_b_uj
);
   import dchrono_pkg::*;

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   logic [DEBOUNCE_W-1:0]  debounce_ff;
   logic [DIST_W-1:0]      dist_ff;
   logic [MASS_W-1:0]      mass_a_ff;
   logic [MASS_W-1:0]      mass_b_ff;

   logic [TIME_WIDTH-1:0]  last_edge_ff, last_edge_in;
   logic [TIME_WIDTH-1:0]  last_acc_ff, last_acc_in;
   logic [TIME_WIDTH-1:0]  interval_ff, interval_in;
   logic                   acc_flag_ff, acc_flag_in;

   // Serial arithmetic: acc is product / dividend / quotient, rem the partial
   // remainder, mplr the multiplier bits consumed MSB first.
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [TIME_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIST_W-1:0]      mplr_ff, mplr_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [RESULT_W-1:0]    speed_ff, speed_in;
   logic [RESULT_W-1:0]    ea_ff, ea_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_accepted_ff, rsp_accepted_in;
   logic [STAMP_W-1:0]     rsp_interval_ff, rsp_interval_in;
   logic                   rsp_speed_valid_ff, rsp_speed_valid_in;
   logic [RESULT_W-1:0]    rsp_speed_ff, rsp_speed_in;
   logic [RESULT_W-1:0]    rsp_ea_ff, rsp_ea_in;
   logic [RESULT_W-1:0]    rsp_eb_ff, rsp_eb_in;

   // ---------------------------------------------------------------------------
   // Edge front end: modular gap for debounce, absolute interval
   // ---------------------------------------------------------------------------
   logic                   req_take;
   logic [TIME_WIDTH-1:0]  t_cur;
   logic [TIME_WIDTH-1:0]  gap;
   logic                   gap_ok;
   logic [TIME_WIDTH-1:0]  abs_dt;
   logic [TIME_WIDTH-1:0]  new_dt;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // Timestamp masked (or zero-extended) to the internal time width.
   assign t_cur  = TIME_WIDTH'(req_edge_time_us);
   assign gap    = t_cur - last_edge_ff;
   assign gap_ok = gap > TIME_WIDTH'(debounce_ff);
   assign abs_dt = (last_acc_ff > t_cur) ? (last_acc_ff - t_cur) : (t_cur - last_acc_ff);
   assign new_dt = gap_ok ? abs_dt : interval_ff;

   // ---------------------------------------------------------------------------
   // Bit-serial datapath
   // ---------------------------------------------------------------------------
   logic [SPEED_BITS-1:0]  dist_k;      // D * 1000 = D*1024 - D*16 - D*8
   logic [ACC_W-1:0]       mcand;
   logic [ACC_W-1:0]       mul_acc;
   logic [TIME_WIDTH:0]    trial;
   logic                   div_ge;
   logic [TIME_WIDTH-1:0]  div_rem;
   logic [ACC_W-1:0]       div_acc;
   logic                   last_iter;
   logic                   rsp_free;
   logic                   dt_nz;

   assign dist_k = (SPEED_BITS'(dist_ff) << 10) - (SPEED_BITS'(dist_ff) << 4)
                 - (SPEED_BITS'(dist_ff) << 3);

   // shift-add multiply step
   assign mcand   = (state_ff == ST_SQ) ? ACC_W'(dist_ff) : ACC_W'(sq_ff);
   assign mul_acc = (acc_ff << 1) + (mplr_ff[DIST_W-1] ? mcand : '0);

   // restoring divide step, divisor is the stored interval
   assign trial   = {rem_ff, acc_ff[ACC_W-1]};
   assign div_ge  = trial >= {1'b0, interval_ff};
   assign div_rem = div_ge ? TIME_WIDTH'(trial - {1'b0, interval_ff})
                           : trial[TIME_WIDTH-1:0];
   assign div_acc = {acc_ff[ACC_W-2:0], div_ge};

   assign last_iter = (cnt_ff == '0);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign dt_nz     = |interval_ff;

   // ---------------------------------------------------------------------------
   // Sequencer: next state and datapath control
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      last_edge_in       = last_edge_ff;
      last_acc_in        = last_acc_ff;
      interval_in        = interval_ff;
      acc_flag_in        = acc_flag_ff;
      acc_in             = acc_ff;
      rem_in             = rem_ff;
      mplr_in            = mplr_ff;
      sq_in              = sq_ff;
      speed_in           = speed_ff;
      ea_in              = ea_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_accepted_in    = rsp_accepted_ff;
      rsp_interval_in    = rsp_interval_ff;
      rsp_speed_valid_in = rsp_speed_valid_ff;
      rsp_speed_in       = rsp_speed_ff;
      rsp_ea_in          = rsp_ea_ff;
      rsp_eb_in          = rsp_eb_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               last_edge_in = t_cur;
               acc_flag_in  = gap_ok;
               if (gap_ok) begin
                  interval_in = abs_dt;
                  last_acc_in = t_cur;
               end
               if (new_dt == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  // dividend left-aligned so 30 steps give the quotient
                  acc_in   = ACC_W'(dist_k) << (ACC_W - SPEED_BITS);
                  rem_in   = '0;
                  cnt_in   = CNT_W'(SPEED_BITS - 1);
                  state_in = ST_SPEED;
               end
            end
         end

         ST_SPEED: begin
            acc_in = div_acc;
            rem_in = div_rem;
            cnt_in = cnt_ff - CNT_W'(1);
            if (last_iter) begin
               speed_in = RESULT_W'(div_acc[SPEED_BITS-1:0]);
               acc_in   = '0;
               mplr_in  = dist_ff;
               cnt_in   = CNT_W'(DIST_W - 1);
               state_in = ST_SQ;
            end
         end

         ST_SQ: begin
            acc_in  = mul_acc;
            mplr_in = mplr_ff << 1;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (last_iter) begin
               sq_in    = mul_acc[SQ_W-1:0];
               acc_in   = '0;
               mplr_in  = {mass_a_ff, {(DIST_W - MASS_W){1'b0}}};
               cnt_in   = CNT_W'(MASS_W - 1);
               state_in = ST_EA_MUL;
            end
         end

         ST_EA_MUL, ST_EB_MUL: begin
            acc_in  = mul_acc;
            mplr_in = mplr_ff << 1;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (last_iter) begin
               rem_in   = '0;
               cnt_in   = CNT_W'(DIV_ITER - 1);
               state_in = (state_ff == ST_EA_MUL) ? ST_EA_DIV1 : ST_EB_DIV1;
            end
         end

         ST_EA_DIV1, ST_EB_DIV1: begin
            acc_in = div_acc;
            rem_in = div_rem;
            cnt_in = cnt_ff - CNT_W'(1);
            if (last_iter) begin
               // second pass divides the quotient by dt again
               rem_in   = '0;
               cnt_in   = CNT_W'(DIV_ITER - 1);
               state_in = (state_ff == ST_EA_DIV1) ? ST_EA_DIV2 : ST_EB_DIV2;
            end
         end

         ST_EA_DIV2: begin
            acc_in = div_acc;
            rem_in = div_rem;
            cnt_in = cnt_ff - CNT_W'(1);
            if (last_iter) begin
               ea_in    = energy_sat(div_acc);
               acc_in   = '0;
               mplr_in  = {mass_b_ff, {(DIST_W - MASS_W){1'b0}}};
               cnt_in   = CNT_W'(MASS_W - 1);
               state_in = ST_EB_MUL;
            end
         end

         ST_EB_DIV2: begin
            acc_in = div_acc;
            rem_in = div_rem;
            cnt_in = cnt_ff - CNT_W'(1);
            if (last_iter) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // energy b is still in acc; zero interval gates every result
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_accepted_in    = acc_flag_ff;
               rsp_interval_in    = STAMP_W'(interval_ff);
               rsp_speed_valid_in = dt_nz;
               rsp_speed_in       = dt_nz ? speed_ff : '0;
               rsp_ea_in          = dt_nz ? ea_ff : '0;
               rsp_eb_in          = dt_nz ? energy_sat(acc_ff) : '0;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Control and architectural state
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         debounce_ff  <= DEBOUNCE_RESET;
         dist_ff      <= DIST_RESET;
         mass_a_ff    <= MASS_A_RESET;
         mass_b_ff    <= MASS_B_RESET;
         last_edge_ff <= '0;
         last_acc_ff  <= '0;
         interval_ff  <= '0;
         acc_flag_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_edge_ff <= last_edge_in;
         last_acc_ff  <= last_acc_in;
         interval_ff  <= interval_in;
         acc_flag_ff  <= acc_flag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DEBOUNCE: debounce_ff <= csr_wdata[DEBOUNCE_W-1:0];
               CSR_DIST:     dist_ff     <= csr_wdata[DIST_W-1:0];
               CSR_MASS_A:   mass_a_ff   <= csr_wdata[MASS_W-1:0];
               CSR_MASS_B:   mass_b_ff   <= csr_wdata[MASS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      acc_ff             <= acc_in;
      rem_ff             <= rem_in;
      mplr_ff            <= mplr_in;
      sq_ff              <= sq_in;
      speed_ff           <= speed_in;
      ea_ff              <= ea_in;
      rsp_accepted_ff    <= rsp_accepted_in;
      rsp_interval_ff    <= rsp_interval_in;
      rsp_speed_valid_ff <= rsp_speed_valid_in;
      rsp_speed_ff       <= rsp_speed_in;
      rsp_ea_ff          <= rsp_ea_in;
      rsp_eb_ff          <= rsp_eb_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_interval_us = rsp_interval_ff;
   assign rsp_speed_valid = rsp_speed_valid_ff;
   assign rsp_speed_mm_s  = rsp_speed_ff;
   assign rsp_energy_a_uj = rsp_ea_ff;
   assign rsp_energy_b_uj = rsp_eb_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   // an accepted edge always starts work
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ST_IDLE))
      else $error("edge taken but sequencer stayed idle");

   // a finished result with a free output register is delivered at once
   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && rsp_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished result not loaded into output register");

   // invalid speed means every derived result is zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_speed_valid |->
         (rsp_speed_mm_s == '0) && (rsp_energy_a_uj == '0) && (rsp_energy_b_uj == '0))
      else $error("nonzero result with zero interval");

endmodule

/* sim/tb.sv */
// tb: self-checking testbench for debounced_chronograph (edge debounce, interval,
// speed and energy). Depends on dchrono_pkg and design/debounced_chronograph.sv.
`timescale 1ns / 1ps

module tb;
   import dchrono_pkg::*;

   // one result transaction, field for field
   typedef struct packed {
      logic                accepted;
      logic [STAMP_W-1:0]  interval_us;
      logic                speed_valid;
      logic [RESULT_W-1:0] speed_mm_s;
      logic [RESULT_W-1:0] energy_a_uj;
      logic [RESULT_W-1:0] energy_b_uj;
   } shot_type;

   // directed plan: register write, edge checked by the predictor, or edge with
   // its result typed in
   typedef enum logic [1:0] {ROW_REG, ROW_EDGE, ROW_EDGE_FIXED} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] wdata;
      logic [STAMP_W-1:0]    stamp;
      shot_type              want;
   } plan_row_type;

   localparam logic [63:0] PEAK32 = 64'h0000_0000_FFFF_FFFF;
   localparam int PHASES = 10;
   localparam int PHASE_EDGES = 95;
   localparam int DRAIN_CYCLES = 320;   // a little over one full edge computation

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [STAMP_W-1:0] req_edge_time_us = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_accepted;
   logic [STAMP_W-1:0] rsp_interval_us;
   logic rsp_speed_valid;
   logic [RESULT_W-1:0] rsp_speed_mm_s;
   logic [RESULT_W-1:0] rsp_energy_a_uj;
   logic [RESULT_W-1:0] rsp_energy_b_uj;

   debounced_chronograph DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_edge_time_us(req_edge_time_us),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_interval_us (rsp_interval_us),
      .rsp_speed_valid (rsp_speed_valid),
      .rsp_speed_mm_s  (rsp_speed_mm_s),
      .rsp_energy_a_uj (rsp_energy_a_uj),
      .rsp_energy_b_uj (rsp_energy_b_uj)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor: register copies and edge history, as after reset
   // ---------------------------------------------------------------------------
   logic [DEBOUNCE_W-1:0] db_us   = DEBOUNCE_RESET;
   logic [DIST_W-1:0]     dist_um = DIST_RESET;
   logic [MASS_W-1:0]     mass_a  = MASS_A_RESET;
   logic [MASS_W-1:0]     mass_b  = MASS_B_RESET;
   logic [STAMP_W-1:0]    prior_stamp = '0;   // previous edge, passed or not
   logic [STAMP_W-1:0]    hit_stamp   = '0;   // last edge that passed debounce
   logic [STAMP_W-1:0]    held_gap    = '0;   // interval reported with every edge

   shot_type shot_q[$];   // expected result transactions, oldest first
   shot_type want_shot;
   int faults = 0;
   int edges_sent = 0;
   int edges_passed = 0;
   int zero_gap_results = 0;
   int reg_writes = 0;
   logic calm = 1'b0;  // no idling on either side while set

   function automatic logic [RESULT_W-1:0] clip32(input logic [63:0] v);
      return (v > PEAK32) ? PEAK32[RESULT_W-1:0] : v[RESULT_W-1:0];
   endfunction

   // uJ = m * D^2 / (2 * dt^2), floored after each divide, clipped to 32 bits
   function automatic logic [RESULT_W-1:0] energy_uj(input logic [MASS_W-1:0] mass,
                                                     input logic [STAMP_W-1:0] dt);
      logic [63:0] num;
      logic [63:0] dt64;
      logic [63:0] d64;
      d64 = {44'd0, dist_um};
      dt64 = {16'd0, dt};
      num = {48'd0, mass} * d64 * d64;
      if (dt64 > PEAK32)
         return '0;   // dt^2 already beyond any numerator
      return clip32(((num / dt64) / dt64) >> 1);
   endfunction

   function automatic shot_type score_edge(input logic [STAMP_W-1:0] stamp);
      shot_type s;
      logic [STAMP_W-1:0] gap;
      gap = stamp - prior_stamp;   // modular distance
      s = '0;
      s.accepted = gap > {28'd0, db_us};
      if (s.accepted) begin
         held_gap = (hit_stamp > stamp) ? hit_stamp - stamp : stamp - hit_stamp;
         hit_stamp = stamp;
      end
      prior_stamp = stamp;
      s.interval_us = held_gap;
      if (held_gap != '0) begin
         s.speed_valid = 1'b1;
         s.speed_mm_s  = clip32(({44'd0, dist_um} * 64'd1000) / {16'd0, held_gap});
         s.energy_a_uj = energy_uj(mass_a, held_gap);
         s.energy_b_uj = energy_uj(mass_b, held_gap);
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------------
   // Directed plan builders
   // ---------------------------------------------------------------------------
   function automatic plan_row_type reg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = '0;
      r.kind = ROW_REG;
      r.idx = idx;
      r.wdata = data;
      return r;
   endfunction

   function automatic plan_row_type edge_row(input logic [STAMP_W-1:0] stamp);
      plan_row_type r;
      r = '0;
      r.kind = ROW_EDGE;
      r.stamp = stamp;
      return r;
   endfunction

   function automatic plan_row_type fixed_row(input logic [STAMP_W-1:0] stamp,
                                              input logic acc,
                                              input logic [STAMP_W-1:0] ivl,
                                              input logic ok,
                                              input logic [RESULT_W-1:0] spd,
                                              input logic [RESULT_W-1:0] ea,
                                              input logic [RESULT_W-1:0] eb);
      plan_row_type r;
      r = '0;
      r.kind = ROW_EDGE_FIXED;
      r.stamp = stamp;
      r.want = {acc, ivl, ok, spd, ea, eb};
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Driving tasks
   // ---------------------------------------------------------------------------
   // one register write; the next edge or write decides whether wr_en drops
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_DEBOUNCE: db_us   = data[DEBOUNCE_W-1:0];
         CSR_DIST:     dist_um = data[DIST_W-1:0];
         CSR_MASS_A:   mass_a  = data[MASS_W-1:0];
         CSR_MASS_B:   mass_b  = data[MASS_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // Every edge yields a result, so once nothing is outstanding the block is idle.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (shot_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Present one edge transaction and log its expected result at acceptance.
   // valid is left high afterwards; the caller's next action sets it in the
   // same step, so a held valid is never dropped and raised at once.
   task automatic send_edge(input logic [STAMP_W-1:0] stamp, input logic fixed,
                            input shot_type fixed_shot);
      int idle;
      shot_type s;
      idle = 0;
      if (!calm) begin
         // mostly short random gaps, now and then a long one so that edges land
         // on every phase of a result waiting for the receiver
         if ($urandom_range(0, 19) == 0)
            idle = $urandom_range(1, 350);
         while ($urandom_range(0, 99) < 29)
            idle++;
      end
      csr_wr_en <= 1'b0;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_edge_time_us <= stamp;
      do
         @(posedge clock);
      while (req_stall);
      s = score_edge(stamp);
      shot_q.push_back(fixed ? fixed_shot : s);
      edges_sent++;
      if (s.accepted)
         edges_passed++;
      if (!s.speed_valid)
         zero_gap_results++;
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: random stall, occasional long hold, none while calm
   // ---------------------------------------------------------------------------
   int hold_left = 0;

   always @(posedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if ($urandom_range(0, 1999) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(50, 400);
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 29);
      end
   end

   // ---------------------------------------------------------------------------
   // Result checker: each result transaction against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (shot_q.size() == 0) begin
            $error("result transaction with nothing expected");
            faults++;
         end else begin
            want_shot = shot_q.pop_front();
            if (rsp_accepted !== want_shot.accepted) begin
               $error("accepted: expected %0d, got %0d", want_shot.accepted, rsp_accepted);
               faults++;
            end
            if (rsp_interval_us !== want_shot.interval_us) begin
               $error("interval_us: expected %0d, got %0d", want_shot.interval_us,
                      rsp_interval_us);
               faults++;
            end
            if (rsp_speed_valid !== want_shot.speed_valid) begin
               $error("speed_valid: expected %0d, got %0d", want_shot.speed_valid,
                      rsp_speed_valid);
               faults++;
            end
            if (rsp_speed_mm_s !== want_shot.speed_mm_s) begin
               $error("speed_mm_s: expected %0d, got %0d", want_shot.speed_mm_s,
                      rsp_speed_mm_s);
               faults++;
            end
            if (rsp_energy_a_uj !== want_shot.energy_a_uj) begin
               $error("energy_a_uj: expected %0d, got %0d", want_shot.energy_a_uj,
                      rsp_energy_a_uj);
               faults++;
            end
            if (rsp_energy_b_uj !== want_shot.energy_b_uj) begin
               $error("energy_b_uj: expected %0d, got %0d", want_shot.energy_b_uj,
                      rsp_energy_b_uj);
               faults++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   plan_row_type plan[$];
   plan_row_type row;
   logic after_edge;
   logic [STAMP_W-1:0] stamp;
   logic [STAMP_W-1:0] span;
   logic [63:0] wide;
   int roll;

   initial begin
      // After reset: time zero sits on the history, the boundary gap is rejected
      plan.push_back(fixed_row(48'd0, 1'b0, 48'd0, 1'b0, 32'd0, 32'd0, 32'd0));
      plan.push_back(fixed_row(48'd200, 1'b0, 48'd0, 1'b0, 32'd0, 32'd0, 32'd0));
      plan.push_back(edge_row(48'd401));          // first pass, measured from zero
      plan.push_back(edge_row(48'd402));          // bounce
      // top of the time range: huge interval, speed and energies fall to zero
      plan.push_back(fixed_row(48'hFFFF_FFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FE6E, 1'b1,
                               32'd0, 32'd0, 32'd0));
      // counter wrap, still within debounce
      plan.push_back(fixed_row(48'd100, 1'b0, 48'hFFFF_FFFF_FE6E, 1'b1,
                               32'd0, 32'd0, 32'd0));
      // past the wrap: absolute difference to the older, larger stamp
      plan.push_back(fixed_row(48'd402, 1'b1, 48'hFFFF_FFFF_FE6D, 1'b1,
                               32'd0, 32'd0, 32'd0));
      plan.push_back(edge_row(48'd1000));
      plan.push_back(edge_row(48'd1001));
      // same stamp as the last pass: accepted, interval zero, speed invalid
      plan.push_back(fixed_row(48'd1000, 1'b1, 48'd0, 1'b0, 32'd0, 32'd0, 32'd0));
      // no debounce, largest distance, mass a with spare data bits set, mass b zero
      plan.push_back(reg_row(CSR_DEBOUNCE, 20'd0));
      plan.push_back(reg_row(CSR_DIST, 20'hF_FFFF));
      plan.push_back(reg_row(CSR_MASS_A, 20'hF_FFFF));
      plan.push_back(reg_row(CSR_MASS_B, 20'd0));
      plan.push_back(fixed_row(48'd1000, 1'b0, 48'd0, 1'b0, 32'd0, 32'd0, 32'd0));
      plan.push_back(edge_row(48'd2000));
      // one-microsecond interval: top speed, saturated energy, zero mass
      plan.push_back(fixed_row(48'd2001, 1'b1, 48'd1, 1'b1, 32'd1048575000,
                               32'hFFFF_FFFF, 32'd0));
      plan.push_back(fixed_row(48'd2001, 1'b0, 48'd1, 1'b1, 32'd1048575000,
                               32'hFFFF_FFFF, 32'd0));
      // largest debounce, shortest distance, masses swapped round
      plan.push_back(reg_row(CSR_DEBOUNCE, 20'hF_FFFF));
      plan.push_back(reg_row(CSR_DIST, 20'd1));
      plan.push_back(reg_row(CSR_MASS_A, 20'd0));
      plan.push_back(reg_row(CSR_MASS_B, 20'h0_FFFF));
      plan.push_back(fixed_row(48'd1050576, 1'b0, 48'd1, 1'b1, 32'd1000, 32'd0,
                               32'd32767));
      plan.push_back(edge_row(48'd2099152));
      plan.push_back(reg_row(CSR_DEBOUNCE, 20'd200));
      plan.push_back(reg_row(CSR_DIST, 20'd68169));
      plan.push_back(reg_row(CSR_MASS_A, 20'd200));
      plan.push_back(reg_row(CSR_MASS_B, 20'd300));
      plan.push_back(edge_row(48'd2149152));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      after_edge = 1'b0;
      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_REG) begin
            if (after_edge)
               quiesce();
            write_reg(row.idx, row.wdata);
            after_edge = 1'b0;
         end else begin
            send_edge(row.stamp, row.kind == ROW_EDGE_FIXED, row.want);
            after_edge = 1'b1;
         end
      end

      // Random phases: fresh register set each time, then a stream of edges that
      // is mostly plausible shots with bounces, with some noise in between
      for (int ph = 0; ph < PHASES; ph++) begin
         quiesce();
         calm = (ph == 4);
         case ($urandom_range(0, 4))
            0: write_reg(CSR_DEBOUNCE, 20'd0);
            1: write_reg(CSR_DEBOUNCE, 20'hF_FFFF);
            2: write_reg(CSR_DEBOUNCE, 20'd200);
            3: write_reg(CSR_DEBOUNCE, 20'($urandom_range(0, 1000)));
            default: write_reg(CSR_DEBOUNCE, 20'($urandom));
         endcase
         case ($urandom_range(0, 3))
            0: write_reg(CSR_DIST, 20'd1);
            1: write_reg(CSR_DIST, 20'hF_FFFF);
            2: write_reg(CSR_DIST, 20'd68169);
            default: write_reg(CSR_DIST, 20'($urandom_range(1, 20'hF_FFFF)));
         endcase
         case ($urandom_range(0, 3))
            0: write_reg(CSR_MASS_A, 20'd0);
            1: write_reg(CSR_MASS_A, 20'h0_FFFF);
            2: write_reg(CSR_MASS_A, 20'($urandom));
            default: write_reg(CSR_MASS_A, 20'($urandom_range(1, 1000)));
         endcase
         case ($urandom_range(0, 3))
            0: write_reg(CSR_MASS_B, 20'd0);
            1: write_reg(CSR_MASS_B, 20'h0_FFFF);
            2: write_reg(CSR_MASS_B, 20'($urandom));
            default: write_reg(CSR_MASS_B, 20'($urandom_range(1, 1000)));
         endcase

         for (int n = 0; n < PHASE_EDGES; n++) begin
            wide = {$urandom, $urandom};
            case ($urandom_range(0, 3))
               0: span = 48'($urandom_range(0, 64));
               1: span = 48'($urandom_range(0, 5000));
               2: span = 48'($urandom);
               default: span = wide[STAMP_W-1:0];
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 50)          // shot: clears debounce by a random margin
               stamp = prior_stamp + {28'd0, db_us} + 48'd1 + span;
            else if (roll < 68)     // gate bounce inside the debounce window
               stamp = prior_stamp + 48'($urandom_range(0, db_us));
            else if (roll < 76)     // just on or just past the debounce edge
               stamp = prior_stamp + {28'd0, db_us} + 48'($urandom_range(0, 1));
            else if (roll < 86)     // noise anywhere in the timestamp range
               stamp = wide[STAMP_W-1:0];
            else if (roll < 92)     // repeat of the last pass: zero interval if taken
               stamp = hit_stamp;
            else if (roll < 96)     // close below the counter wrap
               stamp = '1 - 48'($urandom_range(0, 3000));
            else                    // slightly backwards in time
               stamp = prior_stamp - 48'($urandom_range(1, 5000));
            send_edge(stamp, 1'b0, '0);
         end
      end

      calm = 1'b0;
      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d edge transactions, %0d passed debounce, %0d with zero interval",
               edges_sent, edges_passed, zero_gap_results);
      $display("%0d register writes over %0d register settings", reg_writes, PHASES + 3);
      if (faults == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog: several times the slowest plausible run
   initial begin
      #50_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
design/dchrono_pkg.sv
design/debounced_chronograph.sv
sim/tb.sv
